@@ hw/rtl/elfe_pkg.sv @@
`default_nettype none
package elfe_pkg;

	localparam int unsigned LEVEL_W     = 16;
	localparam int unsigned TICK_W      = 20;
	localparam int unsigned SLOT_W      = 10;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned EASE_W      = LEVEL_W + 1;
	localparam int unsigned ACC_W       = 2 * LEVEL_W + 1;
	localparam int unsigned REM_W       = 2 * LEVEL_W + BYTE_W;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned DIV_STEPS   = LEVEL_W;
	localparam int unsigned MUL_STEPS   = EASE_W;
	localparam int unsigned BYTE_STEPS  = BYTE_W;
	localparam int unsigned BYTE_IDX_W  = $clog2(BYTE_STEPS);

	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;
	localparam int unsigned REG_IDX_BIT = 2;

	localparam int unsigned DEF_EASE_TABLE_ENTRIES = 256;
	localparam int unsigned DEF_MAX_SLOT           = 512;

	localparam logic [SLOT_W-1:0]  SLOT_RESET   = SLOT_W'(1);
	localparam logic [LEVEL_W-1:0] MASTER_RESET = {LEVEL_W{1'b1}};

	localparam logic REG_SLOT   = 1'b0;
	localparam logic REG_MASTER = 1'b1;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_START = 1'b1;

	localparam logic [63:0]       PI_Q30   = 64'd3373259426;
	localparam logic [63:0]       ONE_Q30  = 64'd1073741824;
	localparam logic [EASE_W-1:0] EASE_ONE = EASE_W'(65536);
	localparam logic [REM_W-1:0]  BYTE_DIV = REM_W'(64'd4294836225);

	localparam logic [7:0] TAYLOR_DIV [8] = '{8'd2, 8'd12, 8'd30, 8'd56,
		8'd90, 8'd132, 8'd182, 8'd240};

	typedef struct packed {
		logic                req_type;
		logic [LEVEL_W-1:0]  target_level;
		logic [TICK_W-1:0]   fade_ms;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot_number;
		logic [BYTE_W-1:0]   slot_value;
	} rsp_t;

	function automatic logic [63:0] cos_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [64:0] sum;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		sum  = $signed({1'b0, ONE_Q30});
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[k-1]);
			if ((k % 2) == 1) begin
				sum = sum - $signed({1'b0, term});
			end else begin
				sum = sum + $signed({1'b0, term});
			end
		end
		return (sum < 0) ? 64'd0 : sum[63:0];
	endfunction

	function automatic logic [EASE_W-1:0] ease_half(input logic [63:0] x);
		logic [63:0] e30;
		e30 = (ONE_Q30 - cos_q30(x)) >> 1;
		return EASE_W'((e30 + 64'd8192) >> 14);
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/elfe_if.sv @@
`default_nettype none
interface elfe_req_if import elfe_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface elfe_rsp_if import elfe_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/eased_light_fade_engine_unit.sv @@
// Channel   Dir  Handshake          Payload
// request   in   valid/ready        req_type, target_level, fade_ms
// result    out  valid/ready        slot_number, slot_value
// config    in   APB, pready high   dmx_slot (0x0), master_level (0x4)
//
// A start item gives no result.
// A tick that finds the fade ended or of zero length runs one shift-add multiply and the
// byte divide; mid-fade it runs a bit-serial divide, two table reads, and three
// shift-add multiplies, then a divide for the output byte.
// The result sits in an output register; the next item is taken while it waits.
// Reset is asynchronous; it clears fade levels and tick counts, and sets master_level to all ones.
`default_nettype none
module eased_light_fade_engine_unit import elfe_pkg::*; #(
	parameter int unsigned EASE_TABLE_ENTRIES = DEF_EASE_TABLE_ENTRIES,
	parameter int unsigned MAX_SLOT           = DEF_MAX_SLOT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	elfe_req_if.sink              request,
	elfe_rsp_if.source            result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int unsigned IW = $clog2(EASE_TABLE_ENTRIES + 1);
	localparam int unsigned SW = LEVEL_W + IW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCALE,
		ST_RD_LO,
		ST_RD_HI,
		ST_M1_INIT,
		ST_MUL1,
		ST_EASE,
		ST_MUL2,
		ST_LEVEL,
		ST_MUL3,
		ST_BYTE_INIT,
		ST_BYTE,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic [LEVEL_W-1:0]  cur_q;
	logic [LEVEL_W-1:0]  start_q;
	logic [LEVEL_W-1:0]  goal_q;
	logic [LEVEL_W-1:0]  master_q;
	logic [TICK_W-1:0]   el_q;
	logic [TICK_W-1:0]   len_q;
	logic [SLOT_W-1:0]   slot_q;

	logic [EASE_W-1:0]   a_q;
	logic [EASE_W-1:0]   b_q;
	logic [EASE_W-1:0]   lo_q;
	logic [EASE_W-1:0]   rom_q;
	logic [ACC_W-1:0]    acc_q;
	logic [REM_W-1:0]    rem_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [IW-1:0]       idx_q;

	logic [EASE_W-1:0]   ease_rom [0:EASE_TABLE_ENTRIES];

	logic                req_acc;
	logic                cfg_wr;
	logic [TICK_W-1:0]   new_el;
	logic                at_end;
	logic [TICK_W:0]     div_t;
	logic                div_ge;
	logic [TICK_W:0]     div_sub;
	logic [SW-1:0]       scaled;
	logic [ACC_W-1:0]    mul_sum;
	logic [EASE_W-1:0]   span;
	logic [EASE_W-1:0]   ease_val;
	logic                rising;
	logic [LEVEL_W-1:0]  diff;
	logic [LEVEL_W-1:0]  step;
	logic [LEVEL_W-1:0]  new_level;
	logic [REM_W-1:0]    byte_sub;
	logic                byte_ge;
	logic                last_div;
	logic                last_mul;
	logic                last_byte;

	for (genvar g = 0; g <= EASE_TABLE_ENTRIES; g++) begin : g_ease
		localparam bit               LOWER = (2 * g <= EASE_TABLE_ENTRIES);
		localparam int unsigned      J     = LOWER ? g : EASE_TABLE_ENTRIES - g;
		localparam logic [63:0]      X     = (PI_Q30 * 64'(J)) / 64'(EASE_TABLE_ENTRIES);
		localparam logic [EASE_W-1:0] E    = ease_half(X);
		localparam logic [EASE_W-1:0] V    = LOWER ? E : EASE_ONE - E;
		assign ease_rom[g] = V;
	end

	assign request.ready = (state_q == ST_IDLE);
	assign req_acc       = request.valid & request.ready;
	assign result.valid  = rsp_valid_q;
	assign result.data   = rsp_q;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[REG_IDX_BIT] == REG_MASTER) ? APB_DATA_W'(master_q)
		: APB_DATA_W'(slot_q);

	assign new_el   = (el_q < len_q) ? el_q + TICK_W'(1) : el_q;
	assign at_end   = (len_q == '0) || (new_el >= len_q);

	assign div_t    = {rem_q[TICK_W-1:0], 1'b0};
	assign div_ge   = div_t >= {1'b0, len_q};
	assign div_sub  = div_t - {1'b0, len_q};

	assign scaled   = {{IW{1'b0}}, b_q[LEVEL_W-1:0]} * SW'(EASE_TABLE_ENTRIES);

	assign mul_sum  = {acc_q[ACC_W-2:0], 1'b0} + (b_q[EASE_W-1] ? ACC_W'(a_q) : '0);

	assign span     = (rom_q >= lo_q) ? rom_q - lo_q : '0;
	assign ease_val = lo_q + EASE_W'(acc_q[2*LEVEL_W-1:LEVEL_W]);

	assign rising    = goal_q >= start_q;
	assign diff      = rising ? goal_q - start_q : start_q - goal_q;
	assign step      = acc_q[2*LEVEL_W-1:LEVEL_W];
	assign new_level = rising ? start_q + step : start_q - step;

	assign byte_sub  = BYTE_DIV << cnt_q[BYTE_IDX_W-1:0];
	assign byte_ge   = rem_q >= byte_sub;

	assign last_div  = cnt_q == CNT_W'(DIV_STEPS - 1);
	assign last_mul  = cnt_q == CNT_W'(MUL_STEPS - 1);
	assign last_byte = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			cur_q       <= '0;
			start_q     <= '0;
			goal_q      <= '0;
			el_q        <= '0;
			len_q       <= '0;
			slot_q      <= SLOT_RESET;
			master_q    <= MASTER_RESET;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[REG_IDX_BIT])
					REG_SLOT: begin
						slot_q <= (pwdata[SLOT_W-1:0] > MAX_SLOT) ? SLOT_W'(MAX_SLOT)
							: pwdata[SLOT_W-1:0];
					end
					REG_MASTER: begin
						master_q <= pwdata[LEVEL_W-1:0];
					end
				endcase
			end
			if (result.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (request.data.req_type == REQ_START) begin
							start_q <= cur_q;
							goal_q  <= request.data.target_level;
							len_q   <= request.data.fade_ms;
							el_q    <= '0;
						end else begin
							el_q <= new_el;
							if (at_end) begin
								cur_q   <= goal_q;
								state_q <= ST_MUL3;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (last_div) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE:   state_q <= ST_RD_LO;
				ST_RD_LO:   state_q <= ST_RD_HI;
				ST_RD_HI:   state_q <= ST_M1_INIT;
				ST_M1_INIT: state_q <= ST_MUL1;
				ST_MUL1: begin
					if (last_mul) begin
						state_q <= ST_EASE;
					end
				end
				ST_EASE:    state_q <= ST_MUL2;
				ST_MUL2: begin
					if (last_mul) begin
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					cur_q   <= new_level;
					state_q <= ST_MUL3;
				end
				ST_MUL3: begin
					if (last_mul) begin
						state_q <= ST_BYTE_INIT;
					end
				end
				ST_BYTE_INIT: state_q <= ST_BYTE;
				ST_BYTE: begin
					if (last_byte) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || result.ready) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.slot_number <= slot_q;
						rsp_q.slot_value  <= b_q[BYTE_W-1:0];
						state_q           <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rom_q <= ease_rom[idx_q];
		unique case (state_q) inside
			ST_IDLE: begin
				rem_q <= REM_W'(new_el);
				cnt_q <= '0;
				a_q   <= {1'b0, master_q};
				b_q   <= {1'b0, goal_q};
				acc_q <= '0;
			end
			ST_DIV: begin
				rem_q <= REM_W'(div_ge ? div_sub[TICK_W-1:0] : div_t[TICK_W-1:0]);
				b_q   <= {b_q[EASE_W-2:0], div_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_SCALE: begin
				idx_q <= scaled[SW-1:LEVEL_W];
				b_q   <= {1'b0, scaled[LEVEL_W-1:0]};
			end
			ST_RD_LO: begin
				idx_q <= idx_q + IW'(1);
			end
			ST_RD_HI: begin
				lo_q <= rom_q;
			end
			ST_M1_INIT: begin
				a_q   <= span;
				acc_q <= '0;
				cnt_q <= '0;
			end
			ST_MUL1, ST_MUL2, ST_MUL3: begin
				acc_q <= mul_sum;
				b_q   <= {b_q[EASE_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_EASE: begin
				a_q   <= {1'b0, diff};
				b_q   <= ease_val;
				acc_q <= '0;
				cnt_q <= '0;
			end
			ST_LEVEL: begin
				a_q   <= {1'b0, master_q};
				b_q   <= {1'b0, new_level};
				acc_q <= '0;
				cnt_q <= '0;
			end
			ST_BYTE_INIT: begin
				rem_q <= {acc_q[2*LEVEL_W-1:0], {BYTE_W{1'b0}}}
					- REM_W'(acc_q[2*LEVEL_W-1:0]);
				cnt_q <= CNT_W'(BYTE_STEPS - 1);
			end
			ST_BYTE: begin
				if (byte_ge) begin
					rem_q <= rem_q - byte_sub;
				end
				b_q   <= {b_q[EASE_W-2:0], byte_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/elfe_checker.sv @@
`default_nettype none
module elfe_checker import elfe_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                req_type,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [SLOT_W-1:0]   slot_number,
	input logic [BYTE_W-1:0]   slot_value
);

	logic req_acc;

	assign req_acc = req_valid & req_ready;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(slot_number) && $stable(slot_value))
		else $error("result item changed while stalled");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_type == REQ_TICK) |=> !req_ready)
		else $error("request side ready right after a tick item");

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_type == REQ_START) && !rsp_valid |=> req_ready && !rsp_valid)
		else $error("start item produced a result or blocked the request side");

	a_rsp_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result item appeared without a tick in progress");

endmodule

bind eased_light_fade_engine_unit elfe_checker u_elfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (request.valid),
	.req_ready   (request.ready),
	.req_type    (request.data.req_type),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.slot_number (result.data.slot_number),
	.slot_value  (result.data.slot_value)
);
`default_nettype wire
